// ===== hw/rtl/gni_pkg.sv =====
// Shared constants and payload types of the gravity N-body integrator.
package gni_pkg;

	localparam int MAX_BODIES    = 16;
	localparam int COORD_BITS    = 48;
	localparam int FRAC_BITS     = 32;
	localparam int MASS_BITS     = 33;
	localparam int IDX_BITS      = 4;
	localparam int CNT_BITS      = 5;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SUN   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_3D    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT = 3'd5;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                 func;
		logic [IDX_BITS-1:0]  body_index;
		logic [MASS_BITS-1:0] mass;
		coord_t               pos_x_in;
		coord_t               pos_y_in;
		coord_t               pos_z_in;
		coord_t               vel_x_in;
		coord_t               vel_y_in;
		coord_t               vel_z_in;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] body_out;
		coord_t              pos_x_out;
		coord_t              pos_y_out;
		coord_t              pos_z_out;
		coord_t              vel_x_out;
		coord_t              vel_y_out;
		coord_t              vel_z_out;
		logic                last_body;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		logic [MASS_BITS-1:0] mass;
		logic [2:0][COORD_BITS-1:0] pos;
		logic [2:0][COORD_BITS-1:0] vel;
	} body_t;

	typedef logic [2:0][COORD_BITS-1:0] acc3_t;

endpackage

// ===== hw/rtl/gni_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
interface gni_in_if;
	import gni_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gni_out_if;
	import gni_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gni_cfg_if;
	import gni_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gravity_nbody_integrator.sv =====
// Gravity N-body stepper: sequencer, pair force unit and body update over two RAMs.
// Load writes one body. Advance: a 32-step root and a 61-step divide per body pair per
// force pass, both skipped for a coincident pair; one force pass for Euler, two
// for Verlet; body updates, then bodies reported one at a time. One item at a time.
// Reset restores register defaults and idles the sequencer; the body RAM holds garbage
// until loaded and the acceleration RAM until the first force pass writes it.
module gravity_nbody_integrator (
	input logic clk,
	input logic arst_n,
	gni_in_if.sink    req,
	gni_out_if.source rsp,
	gni_cfg_if.sink   cfg
);
	import gni_pkg::*;

	localparam int CW = COORD_BITS;
	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_JRD    = 5'd1;
	localparam logic [4:0] S_JCAP   = 5'd2;
	localparam logic [4:0] S_KRD    = 5'd3;
	localparam logic [4:0] S_KCAP   = 5'd4;
	localparam logic [4:0] S_NORM   = 5'd5;
	localparam logic [4:0] S_SQ     = 5'd6;
	localparam logic [4:0] S_SQRT   = 5'd7;
	localparam logic [4:0] S_RQ     = 5'd8;
	localparam logic [4:0] S_DIV    = 5'd9;
	localparam logic [4:0] S_MUL    = 5'd10;
	localparam logic [4:0] S_UPD    = 5'd11;
	localparam logic [4:0] S_WR     = 5'd12;
	localparam logic [4:0] S_PIN_RD = 5'd13;
	localparam logic [4:0] S_PIN_WR = 5'd14;
	localparam logic [4:0] S_ORD    = 5'd15;
	localparam logic [4:0] S_OCAP   = 5'd16;

	localparam logic [1:0] P_A1  = 2'd0;
	localparam logic [1:0] P_POS = 2'd1;
	localparam logic [1:0] P_VEL = 2'd2;

	function automatic coord_t sat_add(coord_t a, coord_t b);
		logic [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		if (s[CW] != s[CW-1])
			return s[CW] ? COORD_MIN : COORD_MAX;
		return s[CW-1:0];
	endfunction

	function automatic coord_t from_mag(logic neg, logic [63:0] m);
		logic [63:0] n;
		n = ~m + 64'd1;
		if (m > 64'(COORD_MAX))
			return neg ? COORD_MIN : COORD_MAX;
		return neg ? CW'(n) : CW'(m);
	endfunction

	// control
	logic [4:0]          state_q;
	logic [1:0]          pass_q;
	logic [CNT_BITS-1:0] j_q, k_q;
	logic [5:0]          cnt_q;
	logic                out_valid_q;
	logic [31:0]         step_q, grav_q;
	logic                mode_q, sun_q, three_q;
	logic [CNT_BITS-1:0] count_q;

	// datapath
	logic [31:0]          hsq_q;
	coord_t [2:0]         pj_q, vj_q, a1_q, acc_q;
	logic [MASS_BITS-1:0] mj_q, mk_q;
	logic [2:0][CW:0]     d_q;
	logic [2:0][29:0]     cs_q;
	logic signed [7:0]    e_q;
	logic [61:0]          r2_q;
	logic [32:0]          gm_q;
	logic [63:0]          x_q, res_q;
	logic [30:0]          rs_q;
	logic [29:0]          rq_q;
	logic [3:0][30:0]     rem_q;
	logic [3:0][60:0]     num_q, quo_q;
	logic [59:0]          p_q;
	logic [47:0]          mf_hi_q;
	logic [63:0]          mf_lo_q;
	logic                 mf_neg_q;
	out_item_t            out_q;

	// RAM ports
	logic                body_we, body_re, acc_we, acc_re;
	logic [IDX_BITS-1:0] body_waddr, body_raddr;
	body_t               body_wdata, body_rd;
	acc3_t               acc_rd;

	logic [CNT_BITS-1:0] n_c, first_c;
	logic                in_xfer, out_xfer, out_load;

	assign n_c      = (count_q > CNT_BITS'(MAX_BODIES)) ? CNT_BITS'(MAX_BODIES) : count_q;
	assign first_c  = sun_q ? '0 : CNT_BITS'(1);
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign in_xfer  = req.valid && req.ready;
	assign out_xfer = rsp.valid && rsp.ready;
	assign out_load = (state_q == S_OCAP) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	gni_ram #(.WIDTH($bits(body_t)), .DEPTH(MAX_BODIES)) u_body_ram (
		.clk(clk), .we(body_we), .waddr(body_waddr), .wdata(body_wdata),
		.re(body_re), .raddr(body_raddr), .rdata(body_rd)
	);

	gni_ram #(.WIDTH($bits(acc3_t)), .DEPTH(MAX_BODIES)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(j_q[IDX_BITS-1:0]), .wdata(acc_q),
		.re(acc_re), .raddr(j_q[IDX_BITS-1:0]), .rdata(acc_rd)
	);

	always_comb begin
		body_we    = 1'b0;
		body_waddr = j_q[IDX_BITS-1:0];
		body_wdata = '{mass: mj_q, pos: pj_q, vel: vj_q};
		body_re    = 1'b0;
		body_raddr = j_q[IDX_BITS-1:0];
		acc_re     = (state_q == S_JRD);
		acc_we     = (state_q == S_KRD) && (k_q == n_c) && (pass_q == P_A1);
		unique case (state_q)
			S_IDLE: begin
				body_we    = in_xfer && (req.data.func == FUNC_LOAD);
				body_waddr = req.data.body_index;
				body_wdata = '{mass: req.data.mass,
					pos: {req.data.pos_z_in, req.data.pos_y_in, req.data.pos_x_in},
					vel: {req.data.vel_z_in, req.data.vel_y_in, req.data.vel_x_in}};
			end
			S_JRD, S_ORD: body_re = 1'b1;
			S_KRD: begin
				body_re    = (k_q != n_c) && (k_q != j_q);
				body_raddr = k_q[IDX_BITS-1:0];
			end
			S_WR: body_we = 1'b1;
			S_PIN_RD: begin
				body_re    = 1'b1;
				body_raddr = '0;
			end
			S_PIN_WR: begin
				body_we    = 1'b1;
				body_waddr = '0;
				body_wdata = '{mass: body_rd.mass, pos: '0, vel: '0};
			end
			default: ;
		endcase
	end

	// pair distance normalization
	logic [2:0][CW:0] mg_c;
	logic [CW:0]      big_c;
	logic [5:0]       len_c;
	logic [6:0]       s_c;
	logic [6:0]       sl_c;
	logic [2:0][29:0] cs_c;

	always_comb begin
		big_c = '0;
		len_c = '0;
		for (int c = 0; c < 3; c++) begin
			mg_c[c] = d_q[c][CW] ? (~d_q[c] + (CW+1)'(1)) : d_q[c];
			if (mg_c[c] > big_c)
				big_c = mg_c[c];
		end
		for (int i = 0; i <= CW; i++)
			if (big_c[i])
				len_c = 6'(i + 1);
		s_c  = {1'b0, len_c} - 7'd30;
		sl_c = 7'd0 - s_c;
		for (int c = 0; c < 3; c++)
			cs_c[c] = s_c[6] ? 30'(mg_c[c] << sl_c[5:0]) : 30'(mg_c[c] >> s_c[5:0]);
	end

	// square root step
	logic [63:0] sq_bit_c, sq_sum_c;
	assign sq_bit_c = 64'd1 << (7'd62 - {cnt_q, 1'b0});
	assign sq_sum_c = res_q + sq_bit_c;

	// contribution scaling
	logic [1:0]  mc_c;
	logic [63:0] pm_c;
	logic [7:0]  eneg_c;
	assign mc_c   = 2'(cnt_q - 6'd1);
	assign eneg_c = 8'd0 - e_q;

	always_comb begin
		if (e_q < 0)
			pm_c = 64'(p_q) >> eneg_c[5:0];
		else if ((64'(p_q) >> (6'd47 - e_q[5:0])) != '0)
			pm_c = '1;
		else
			pm_c = 64'(p_q) << e_q[5:0];
	end

	// body update: operand selection for one scaled add
	logic [2:0]  op_c;
	logic [1:0]  comp_c;
	coord_t      src_c;
	logic [31:0] f_c;
	logic        ext_c, to_vel_c, upd_en_c;
	logic [47:0] msrc_c;
	logic [48:0] mf_r_c;
	coord_t      mf_val_c;

	always_comb begin
		op_c     = cnt_q[3:1];
		comp_c   = (op_c >= 3'd3) ? 2'(op_c - 3'd3) : op_c[1:0];
		f_c      = step_q;
		ext_c    = 1'b0;
		to_vel_c = 1'b0;
		if (pass_q == P_VEL) begin
			src_c    = (op_c < 3'd3) ? a1_q[comp_c] : acc_q[comp_c];
			ext_c    = 1'b1;
			to_vel_c = 1'b1;
		end else if (op_c < 3'd3) begin
			src_c = vj_q[comp_c];
		end else begin
			src_c    = a1_q[comp_c];
			f_c      = mode_q ? hsq_q : step_q;
			to_vel_c = !mode_q;
		end
		msrc_c   = src_c[CW-1] ? (~src_c + CW'(1)) : src_c;
		mf_r_c   = (49'(mf_hi_q) + 49'(mf_lo_q[63:32])) >> ext_c;
		mf_val_c = from_mag(mf_neg_q, 64'(mf_r_c));
		upd_en_c = (comp_c != 2'd2) || three_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= P_A1;
			j_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			step_q      <= 32'd42949673;
			grav_q      <= 32'd662337941;
			mode_q      <= 1'b0;
			sun_q       <= 1'b0;
			three_q     <= 1'b0;
			count_q     <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.data.index)
					CFG_STEP:  step_q  <= cfg.data.wdata;
					CFG_GRAV:  grav_q  <= cfg.data.wdata;
					CFG_MODE:  mode_q  <= cfg.data.wdata[0];
					CFG_SUN:   sun_q   <= cfg.data.wdata[0];
					CFG_3D:    three_q <= cfg.data.wdata[0];
					CFG_COUNT: count_q <= cfg.data.wdata[CNT_BITS-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && req.data.func == FUNC_ADVANCE && n_c != '0) begin
						pass_q  <= P_A1;
						j_q     <= first_c;
						state_q <= S_JRD;
					end
				end
				S_JRD: begin
					if (j_q >= n_c) begin
						priority case (pass_q)
							P_A1: begin
								pass_q <= P_POS;
								j_q    <= first_c;
							end
							P_POS: begin
								if (!sun_q)
									state_q <= S_PIN_RD;
								else if (mode_q) begin
									pass_q <= P_VEL;
									j_q    <= first_c;
								end else begin
									j_q     <= '0;
									state_q <= S_ORD;
								end
							end
							default: begin
								j_q     <= '0;
								state_q <= S_ORD;
							end
						endcase
					end else
						state_q <= S_JCAP;
				end
				S_JCAP: begin
					k_q     <= '0;
					cnt_q   <= '0;
					state_q <= (pass_q == P_POS) ? S_UPD : S_KRD;
				end
				S_KRD: begin
					if (k_q == n_c) begin
						if (pass_q == P_A1) begin
							j_q     <= j_q + CNT_BITS'(1);
							state_q <= S_JRD;
						end else begin
							cnt_q   <= '0;
							state_q <= S_UPD;
						end
					end else if (k_q == j_q)
						k_q <= k_q + CNT_BITS'(1);
					else
						state_q <= S_KCAP;
				end
				S_KCAP: state_q <= S_NORM;
				S_NORM: begin
					cnt_q <= '0;
					if (big_c == '0) begin
						k_q     <= k_q + CNT_BITS'(1);
						state_q <= S_KRD;
					end else
						state_q <= S_SQ;
				end
				S_SQ: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31)
						state_q <= S_RQ;
				end
				S_RQ: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'd60) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						k_q     <= k_q + CNT_BITS'(1);
						state_q <= S_KRD;
					end
				end
				S_UPD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd11)
						state_q <= S_WR;
				end
				S_WR: begin
					j_q     <= j_q + CNT_BITS'(1);
					state_q <= S_JRD;
				end
				S_PIN_RD: state_q <= S_PIN_WR;
				S_PIN_WR: begin
					if (mode_q) begin
						pass_q  <= P_VEL;
						j_q     <= first_c;
						state_q <= S_JRD;
					end else begin
						j_q     <= '0;
						state_q <= S_ORD;
					end
				end
				S_ORD: state_q <= S_OCAP;
				S_OCAP: begin
					if (out_load) begin
						if (j_q == n_c - CNT_BITS'(1))
							state_q <= S_IDLE;
						else begin
							j_q     <= j_q + CNT_BITS'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hsq_q <= 32'((64'(step_q) * 64'(step_q)) >> 33);
		unique case (state_q)
			S_JCAP: begin
				pj_q  <= body_rd.pos;
				vj_q  <= body_rd.vel;
				mj_q  <= body_rd.mass;
				a1_q  <= acc_rd;
				acc_q <= '0;
			end
			S_KCAP: begin
				mk_q   <= body_rd.mass;
				d_q[0] <= {body_rd.pos[0][CW-1], body_rd.pos[0]} - {pj_q[0][CW-1], pj_q[0]};
				d_q[1] <= {body_rd.pos[1][CW-1], body_rd.pos[1]} - {pj_q[1][CW-1], pj_q[1]};
				d_q[2] <= three_q ?
					({body_rd.pos[2][CW-1], body_rd.pos[2]} - {pj_q[2][CW-1], pj_q[2]}) : '0;
			end
			S_NORM: begin
				cs_q <= cs_c;
				e_q  <= $signed(8'hF4 - {s_c, 1'b0});
				r2_q <= '0;
			end
			S_SQ: begin
				if (cnt_q < 6'd3)
					r2_q <= r2_q + 62'(60'(cs_q[cnt_q[1:0]]) * 60'(cs_q[cnt_q[1:0]]));
				else begin
					gm_q  <= (mk_q[32] ? 33'(grav_q) : 33'd0)
						+ 33'((64'(grav_q) * 64'(mk_q[31:0])) >> 32);
					x_q   <= 64'(r2_q);
					res_q <= '0;
				end
			end
			S_SQRT: begin
				if (x_q >= sq_sum_c) begin
					x_q   <= x_q - sq_sum_c;
					res_q <= (res_q >> 1) + sq_bit_c;
				end else
					res_q <= res_q >> 1;
			end
			S_RQ: begin
				rs_q     <= res_q[30:0];
				rq_q     <= 30'((62'(res_q[30:0]) * 62'(res_q[30:0])) >> 32);
				num_q[0] <= {gm_q, 28'd0};
				for (int c = 0; c < 3; c++)
					num_q[c+1] <= 61'({cs_q[c], 24'd0});
				rem_q    <= '0;
				quo_q    <= '0;
			end
			S_DIV: begin
				for (int i = 0; i < 4; i++) begin
					logic [31:0] r, dv;
					r  = {rem_q[i], num_q[i][60]};
					dv = (i == 0) ? 32'(rq_q) : 32'(rs_q);
					if (r >= dv) begin
						rem_q[i] <= 31'(r - dv);
						quo_q[i] <= {quo_q[i][59:0], 1'b1};
					end else begin
						rem_q[i] <= r[30:0];
						quo_q[i] <= {quo_q[i][59:0], 1'b0};
					end
					num_q[i] <= {num_q[i][59:0], 1'b0};
				end
			end
			S_MUL: begin
				if (cnt_q < 6'd3)
					p_q <= 60'(quo_q[0][34:0]) * 60'(quo_q[cnt_q[1:0] + 2'd1][24:0]);
				if (cnt_q != 6'd0)
					acc_q[mc_c] <= sat_add(acc_q[mc_c], from_mag(d_q[mc_c][CW], pm_c));
			end
			S_UPD: begin
				if (!cnt_q[0]) begin
					mf_hi_q  <= 48'(msrc_c[47:32]) * 48'(f_c);
					mf_lo_q  <= 64'(msrc_c[31:0]) * 64'(f_c);
					mf_neg_q <= src_c[CW-1];
				end else if (upd_en_c) begin
					if (to_vel_c)
						vj_q[comp_c] <= sat_add(vj_q[comp_c], mf_val_c);
					else
						pj_q[comp_c] <= sat_add(pj_q[comp_c], mf_val_c);
				end
			end
			S_OCAP: begin
				if (out_load) begin
					out_q.body_out  <= j_q[IDX_BITS-1:0];
					out_q.pos_x_out <= body_rd.pos[0];
					out_q.pos_y_out <= body_rd.pos[1];
					out_q.pos_z_out <= three_q ? body_rd.pos[2] : '0;
					out_q.vel_x_out <= body_rd.vel[0];
					out_q.vel_y_out <= body_rd.vel[1];
					out_q.vel_z_out <= three_q ? body_rd.vel[2] : '0;
					out_q.last_body <= (j_q == n_c - CNT_BITS'(1));
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q[0] < {1'b0, rq_q}) && (rem_q[1] < rs_q))
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RQ) |-> (res_q[63:31] == '0) && (res_q[30:29] != 2'b00))
		else $error("normalized distance root out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KCAP) |-> (k_q != j_q) && (k_q < n_c))
		else $error("pair unit fed a self pair or an unused body");

endmodule

// ===== hw/rtl/gni_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gni_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
